FILE: sv/text_console_writer_macros.svh
// Assertion macros shared by the console writer checker.
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define TCW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/tcw_pkg.sv
// Types and constants shared by the text console writer and its checker.
package tcw_pkg;

    // Request codes
    localparam logic [1:0] REQ_PUT   = 2'd0;
    localparam logic [1:0] REQ_CLEAR = 2'd1;
    localparam logic [1:0] REQ_SETC  = 2'd2;
    localparam logic [1:0] REQ_READ  = 2'd3;

    // Character codes
    localparam logic [7:0] NEWLINE_CODE = 8'h0a;
    localparam logic [7:0] SPACE_CODE   = 8'h20;

    // Default screen geometry
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // Width of the reported cursor position
    localparam int CURSOR_W = 11;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] char_code;
        logic [3:0] background;
        logic [3:0] foreground;
        logic [7:0] col;
        logic [7:0] row;
    } t_in;

    typedef struct packed {
        logic [CURSOR_W-1:0] cursor_loc;
        logic                scrolled;
        logic [7:0]          cell_char;
        logic [7:0]          cell_style;
    } t_out;

endpackage

FILE: sv/text_console_writer.sv
// Text console writer: cell store, cursor and request sequencer.
//
// A COLUMNS x ROWS text screen held in one single-port-write, registered-read
// memory of 16-bit cells (style byte high, character byte low). One request
// is taken at a time and each yields one result item. A put or a newline that
// does not scroll goes from accept straight to the result. A read steps through
// address, memory read, capture and result. Set cursor runs a subtract loop
// that splits the column into row and column; a position past the last cell
// skips the loop. Clear and a scroll step through every cell, bound by the
// memory doing one cell per cycle. A stalled result holds the block in its
// done state. After reset the block zeroes every memory cell with o_in_stall
// high.
module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  tcw_pkg::t_in  i_in_item,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output tcw_pkg::t_out o_out_item
);
    import tcw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int KW    = $clog2(CELLS + 1);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int LW    = $clog2(255 * COLUMNS + 256);

    localparam logic [AW-1:0] LAST_A      = AW'(CELLS - 1);
    localparam logic [AW-1:0] SCROLL_BASE = AW'(CELLS - COLUMNS);
    localparam logic [AW-1:0] COLS_A      = AW'(COLUMNS);
    localparam logic [LW-1:0] LAST_L      = LW'(CELLS - 1);
    localparam logic [KW-1:0] LAST_K      = KW'(CELLS - 1);
    localparam logic [KW-1:0] CELLS_K     = KW'(CELLS);
    localparam logic [KW-1:0] MOVE_END_K  = KW'(CELLS - COLUMNS);
    localparam logic [RW-1:0] LAST_ROW    = RW'(ROWS - 1);
    localparam logic [CW-1:0] LAST_COL    = CW'(COLUMNS - 1);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_SCROLL,
        S_SETC,
        S_RD_ADDR,
        S_RD_DATA,
        S_DONE
    } t_state;

    t_state        r_state;
    logic [AW-1:0] r_cursor;
    logic [RW-1:0] r_cur_row;
    logic [CW-1:0] r_cur_col;
    logic [KW-1:0] r_k;
    logic          r_wr_pend;
    logic [AW-1:0] r_wr_addr;
    logic          r_wr_blank;
    logic [15:0]   r_fill;
    logic [LW-1:0] r_lin;
    logic [7:0]    r_div_col;
    logic [7:0]    r_div_row;
    logic          r_scrolled;
    logic [7:0]    r_cell_char;
    logic [7:0]    r_cell_style;
    logic          r_out_valid;
    t_out          r_out;
    logic [15:0]   r_rd_data;

    logic [15:0]   mem [CELLS];

    logic          in_acc;
    logic          out_free;
    logic [LW-1:0] lin_pos;
    logic [AW-1:0] lin_clamped;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [15:0]   mem_wdata;
    logic [AW-1:0] mem_raddr;

    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign out_free    = !r_out_valid || !i_out_stall;

    // Linear position of the requested row and column
    assign lin_pos     = LW'(i_in_item.row) * LW'(COLUMNS) + LW'(i_in_item.col);
    assign lin_clamped = (r_lin > LAST_L) ? LAST_A : r_lin[AW-1:0];

    // Memory port steering
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_wr_addr;
        mem_wdata = r_fill;
        mem_raddr = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && i_in_item.req_type == REQ_PUT
                        && i_in_item.char_code != NEWLINE_CODE) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_cursor;
                    mem_wdata = {i_in_item.background, i_in_item.foreground,
                                 i_in_item.char_code};
                end
            end
            S_INIT, S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_k[AW-1:0];
                mem_wdata = r_fill;
            end
            S_SCROLL: begin
                // read one row ahead, write the cell read last cycle
                mem_raddr = (r_k < MOVE_END_K) ? r_k[AW-1:0] + COLS_A : r_k[AW-1:0];
                mem_we    = r_wr_pend;
                mem_wdata = r_wr_blank ? {r_rd_data[15:8], SPACE_CODE} : r_rd_data;
            end
            S_RD_ADDR: begin
                mem_raddr = lin_clamped;
            end
            default: begin
            end
        endcase
    end

    // Cell store
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= mem[mem_raddr];
    end

    // Request sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_k         <= '0;
            r_fill      <= '0;
            r_cursor    <= '0;
            r_cur_row   <= '0;
            r_cur_col   <= '0;
            r_wr_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // taken result drops unless a new one replaces it this cycle
            if (r_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_INIT: begin
                    r_k <= r_k + 1'b1;
                    if (r_k == LAST_K) begin
                        r_state <= S_IDLE;
                    end
                end

                S_IDLE: begin
                    if (in_acc) begin
                        r_scrolled   <= (i_in_item.req_type == REQ_PUT)
                                        && (i_in_item.char_code == NEWLINE_CODE)
                                        && (r_cur_row == LAST_ROW);
                        r_cell_char  <= '0;
                        r_cell_style <= '0;
                        r_k          <= '0;
                        r_wr_pend    <= 1'b0;
                        r_lin        <= lin_pos;
                        r_div_col    <= i_in_item.col;
                        r_div_row    <= i_in_item.row;
                        unique case (i_in_item.req_type)
                            REQ_PUT: begin
                                if (i_in_item.char_code == NEWLINE_CODE) begin
                                    r_cur_col <= '0;
                                    if (r_cur_row == LAST_ROW) begin
                                        r_cursor   <= SCROLL_BASE;
                                        r_state    <= S_SCROLL;
                                    end else begin
                                        r_cursor  <= r_cursor + COLS_A - AW'(r_cur_col);
                                        r_cur_row <= r_cur_row + 1'b1;
                                        r_state   <= S_DONE;
                                    end
                                end else begin
                                    // cell written by the port logic; cursor stops at the end
                                    if (r_cursor != LAST_A) begin
                                        r_cursor <= r_cursor + 1'b1;
                                        if (r_cur_col == LAST_COL) begin
                                            r_cur_col <= '0;
                                            r_cur_row <= r_cur_row + 1'b1;
                                        end else begin
                                            r_cur_col <= r_cur_col + 1'b1;
                                        end
                                    end
                                    r_state <= S_DONE;
                                end
                            end
                            REQ_CLEAR: begin
                                r_fill  <= {i_in_item.background, i_in_item.foreground,
                                            SPACE_CODE};
                                r_state <= S_CLEAR;
                            end
                            REQ_SETC: begin
                                r_state <= S_SETC;
                            end
                            REQ_READ: begin
                                r_state <= S_RD_ADDR;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end

                S_CLEAR: begin
                    r_k <= r_k + 1'b1;
                    if (r_k == LAST_K) begin
                        r_state <= S_DONE;
                    end
                end

                S_SCROLL: begin
                    if (r_k != CELLS_K) begin
                        r_wr_pend  <= 1'b1;
                        r_wr_addr  <= r_k[AW-1:0];
                        r_wr_blank <= (r_k >= MOVE_END_K);
                        r_k        <= r_k + 1'b1;
                    end else begin
                        r_wr_pend <= 1'b0;
                        r_state   <= S_DONE;
                    end
                end

                S_SETC: begin
                    // split the column into whole rows and a remainder
                    if (r_lin > LAST_L) begin
                        r_cursor  <= LAST_A;
                        r_cur_row <= LAST_ROW;
                        r_cur_col <= LAST_COL;
                        r_state   <= S_DONE;
                    end else if ({1'b0, r_div_col} >= 9'(COLUMNS)) begin
                        r_div_col <= r_div_col - 8'(COLUMNS);
                        r_div_row <= r_div_row + 1'b1;
                    end else begin
                        r_cursor  <= r_lin[AW-1:0];
                        r_cur_row <= r_div_row[RW-1:0];
                        r_cur_col <= r_div_col[CW-1:0];
                        r_state   <= S_DONE;
                    end
                end

                S_RD_ADDR: begin
                    r_state <= S_RD_DATA;
                end

                S_RD_DATA: begin
                    r_cell_char  <= r_rd_data[7:0];
                    r_cell_style <= r_rd_data[15:8];
                    r_state      <= S_DONE;
                end

                S_DONE: begin
                    if (out_free) begin
                        r_out_valid      <= 1'b1;
                        r_out.cursor_loc <= CURSOR_W'(r_cursor);
                        r_out.scrolled   <= r_scrolled;
                        r_out.cell_char  <= r_cell_char;
                        r_out.cell_style <= r_cell_style;
                        r_state          <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: sv/tcw_checker.sv
// Port-level checker for the text console writer, bound into text_console_writer.
`include "text_console_writer_macros.svh"

module tcw_checker #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          i_in_stall,
    input logic          i_out_valid,
    input logic          i_out_stall,
    input tcw_pkg::t_out i_out_item
);
    import tcw_pkg::*;

    localparam int                 CELLS     = COLUMNS * ROWS;
    localparam bit                 FITS      = (CELLS <= (1 << CURSOR_W));
    localparam logic [CURSOR_W-1:0] LAST_C   = CURSOR_W'(CELLS - 1);
    localparam logic [CURSOR_W-1:0] SCROLL_C = CURSOR_W'(CELLS - COLUMNS);

    logic scroll_ok;

    // Scroll result: start of the last row, no cell data
    assign scroll_ok = (i_out_item.cursor_loc == SCROLL_C) && (i_out_item.cell_char == 8'd0)
                       && (i_out_item.cell_style == 8'd0);

    // A held result keeps its value
    `TCW_ASSERT_NEXT(a_out_hold, i_out_valid && i_out_stall, i_out_valid && $stable(i_out_item), "result changed while stalled")

    // One request at a time: input closes right after an accept
    `TCW_ASSERT_NEXT(a_one_at_a_time, i_in_valid && !i_in_stall, i_in_stall, "input open after accept")

    // Cursor never runs past the last cell
    `TCW_ASSERT_NOW(a_cursor_range, i_out_valid, !FITS || (i_out_item.cursor_loc <= LAST_C), "cursor beyond last cell")

    // A scroll leaves the cursor at the start of the last row and reads nothing
    `TCW_ASSERT_NOW(a_scroll_result, i_out_valid && i_out_item.scrolled, scroll_ok, "bad scroll result")

endmodule

bind text_console_writer tcw_checker #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
) u_tcw_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .i_in_stall (o_in_stall),
    .i_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .i_out_item (o_out_item)
);

FILE: verif/tb.sv
// Self-checking testbench for the text console writer: cell store and cursor prediction.
`timescale 1ns / 1ps

import tcw_pkg::*;

// Tracks the expected screen and cursor and compares every result item
class console_scoreboard;
    localparam int COLS      = DEF_COLUMNS;
    localparam int LINES     = DEF_ROWS;
    localparam int CELLS     = COLS * LINES;
    localparam int LAST_CELL = CELLS - 1;

    // Character in the low byte, style in the high byte
    bit [15:0]   screen [CELLS];
    int unsigned cursor;
    t_out        expected_q[$];

    int unsigned failures;
    int unsigned checked;
    int unsigned accepted;
    int unsigned puts;
    int unsigned scrolls;
    int unsigned clears;
    int unsigned reads;

    function new();
        foreach (screen[k]) screen[k] = '0;
        cursor   = 0;
        failures = 0;
        checked  = 0;
        accepted = 0;
        puts     = 0;
        scrolls  = 0;
        clears   = 0;
        reads    = 0;
    endfunction

    // Rows move up one; the bottom row keeps its styles but turns to spaces
    function void scroll_screen();
        for (int k = 0; k < CELLS - COLS; k++) screen[k] = screen[k + COLS];
        for (int k = CELLS - COLS; k < CELLS; k++) screen[k][7:0] = SPACE_CODE;
        cursor = COLS * (LINES - 1);
    endfunction

    // Apply one accepted request to the screen and queue its result
    function void note_request(t_in req);
        t_out        want;
        bit [7:0]    style;
        int unsigned pos;
        want     = '0;
        style    = {req.background, req.foreground};
        accepted++;
        case (req.req_type)
            REQ_PUT: begin
                puts++;
                if (req.char_code == NEWLINE_CODE) begin
                    if (cursor / COLS + 1 >= LINES) begin
                        scroll_screen();
                        want.scrolled = 1'b1;
                        scrolls++;
                    end else begin
                        cursor = (cursor / COLS + 1) * COLS;
                    end
                end else begin
                    screen[cursor] = {style, req.char_code};
                    if (cursor < LAST_CELL) cursor++;
                end
            end
            REQ_CLEAR: begin
                clears++;
                foreach (screen[k]) screen[k] = {style, SPACE_CODE};
            end
            default: begin
                pos = int'(req.col) + COLS * int'(req.row);
                if (pos > LAST_CELL) pos = LAST_CELL;
                if (req.req_type == REQ_SETC) begin
                    cursor = pos;
                end else begin
                    reads++;
                    want.cell_char  = screen[pos][7:0];
                    want.cell_style = screen[pos][15:8];
                end
            end
        endcase
        want.cursor_loc = cursor[CURSOR_W-1:0];
        expected_q.push_back(want);
    endfunction

    function void report_field(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
            failures++;
        end
    endfunction

    // Compare one result item with the oldest expectation
    function void check_result(t_out got);
        t_out want;
        if (expected_q.size() == 0) begin
            $display("%0t: result with nothing expected, actual %p", $time, got);
            failures++;
            return;
        end
        want = expected_q.pop_front();
        checked++;
        report_field("cursor_loc", want.cursor_loc, got.cursor_loc);
        report_field("scrolled", want.scrolled, got.scrolled);
        report_field("cell_char", want.cell_char, got.cell_char);
        report_field("cell_style", want.cell_style, got.cell_style);
    endfunction

    function int unsigned pending();
        return expected_q.size();
    endfunction

    function void finish_check();
        if (expected_q.size() != 0) begin
            $display("%0t: %0d results never arrived, oldest expected %p",
                     $time, expected_q.size(), expected_q[0]);
            failures++;
        end
    endfunction
endclass

module tb;
    localparam int          COLS        = DEF_COLUMNS;
    localparam int          LINES       = DEF_ROWS;
    localparam int          ITEM_TARGET = 400;
    localparam int          TAIL_ITEMS  = 60;
    localparam int unsigned CYCLE_LIMIT = 4_000_000;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_in  i_in_item;
    logic o_out_valid;
    logic i_out_stall;
    t_out o_out_item;

    console_scoreboard board = new();

    int unsigned cycle_count   = 0;
    int unsigned sent_count    = 0;
    int unsigned in_gap_pct    = 0;
    int unsigned out_stall_pct = 0;
    bit          calm_tail     = 1'b0;

    text_console_writer #(
        .COLUMNS (COLS),
        .ROWS    (LINES)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Cycle budget; a hung handshake ends the run here
    initial begin
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("%0t: timeout after %0d cycles, %0d results outstanding",
                         $time, cycle_count, board.pending());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Output backpressure in bursts; the stall rate is redrawn between 0 and 20 percent as the run goes on
    initial begin
        int unsigned span;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!calm_tail && $urandom_range(0, 99) < out_stall_pct) begin
                i_out_stall <= 1'b1;
                span = $urandom_range(1, 8);
                repeat (span) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            if (cycle_count % 128 == 0)
                out_stall_pct = ($urandom_range(0, 2) == 0) ? 0 : 20;
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) board.check_result(o_out_item);
    end

    function automatic t_in put_req(logic [7:0] ch, logic [3:0] bg, logic [3:0] fg);
        t_in r;
        r.req_type   = REQ_PUT;
        r.char_code  = ch;
        r.background = bg;
        r.foreground = fg;
        r.col        = 8'($urandom);
        r.row        = 8'($urandom);
        return r;
    endfunction

    // Set cursor or read cell at (col, row); unused fields carry noise
    function automatic t_in pos_req(logic [1:0] kind, logic [7:0] c, logic [7:0] r_row);
        t_in r;
        r.req_type   = kind;
        r.char_code  = 8'($urandom);
        r.background = 4'($urandom);
        r.foreground = 4'($urandom);
        r.col        = c;
        r.row        = r_row;
        return r;
    endfunction

    function automatic t_in clear_req(logic [3:0] bg, logic [3:0] fg);
        t_in r;
        r            = put_req(8'($urandom), bg, fg);
        r.req_type   = REQ_CLEAR;
        return r;
    endfunction

    // Present one item, with an optional idle burst ahead of it, and wait for it to be taken
    task automatic send_request(t_in req);
        int unsigned gap;
        if (!calm_tail && $urandom_range(0, 99) < in_gap_pct) begin
            i_in_valid <= 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= req;
        do @(posedge i_clk); while (o_in_stall);
        board.note_request(req);
        sent_count++;
    endtask

    // A line of text at a random spot, then a read back of its first cells
    task automatic text_run();
        logic [7:0]  c0;
        logic [7:0]  r0;
        int unsigned len;
        int unsigned nreads;
        logic [7:0]  ch;
        c0 = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, COLS - 1));
        r0 = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, LINES - 1));
        send_request(pos_req(REQ_SETC, c0, r0));
        len = $urandom_range(1, 10);
        repeat (len) begin
            ch = ($urandom_range(0, 7) == 0) ? NEWLINE_CODE : 8'($urandom);
            send_request(put_req(ch, 4'($urandom), 4'($urandom)));
        end
        nreads = $urandom_range(1, 3);
        for (int k = 0; k < nreads; k++)
            send_request(pos_req(REQ_READ, c0 + 8'(k), r0));
    endtask

    // Optional text on the bottom row, a newline that scrolls, then reads of the last two rows
    task automatic bottom_scroll();
        logic [7:0] bottom;
        bottom = ($urandom_range(0, 1) == 0) ? 8'(LINES - 1) : 8'($urandom_range(LINES - 1, 255));
        send_request(pos_req(REQ_SETC, 8'($urandom_range(0, COLS - 1)), bottom));
        if ($urandom_range(0, 1) == 0)
            send_request(put_req(8'($urandom_range(33, 126)), 4'($urandom), 4'($urandom)));
        send_request(put_req(NEWLINE_CODE, 4'($urandom), 4'($urandom)));
        send_request(pos_req(REQ_READ, 8'($urandom_range(0, COLS - 1)), 8'(LINES - 2)));
        send_request(pos_req(REQ_READ, 8'($urandom_range(0, COLS - 1)), 8'(LINES - 1)));
    endtask

    // Any request with any field values; clears kept rare
    task automatic noise_item();
        t_in r;
        r.req_type   = 2'($urandom);
        r.char_code  = 8'($urandom);
        r.background = 4'($urandom);
        r.foreground = 4'($urandom);
        r.col        = 8'($urandom);
        r.row        = 8'($urandom);
        if (r.req_type == REQ_CLEAR && $urandom_range(0, 3) != 0) r.req_type = REQ_READ;
        send_request(r);
    endtask

    initial begin
        int unsigned pick;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_item  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes, cursor clamp, scroll, clear
        send_request(pos_req(REQ_READ, 8'd0, 8'd0));
        send_request(put_req(8'h41, 4'hf, 4'h0));
        send_request(put_req(8'h00, 4'h0, 4'hf));
        send_request(put_req(8'hff, 4'ha, 4'h5));
        send_request(pos_req(REQ_READ, 8'd0, 8'd0));
        send_request(pos_req(REQ_READ, 8'd2, 8'd0));
        send_request(put_req(NEWLINE_CODE, 4'h1, 4'h2));
        send_request(pos_req(REQ_SETC, 8'hff, 8'hff));
        send_request(put_req(8'h5a, 4'h3, 4'hc));
        send_request(put_req(8'h59, 4'hc, 4'h3));
        send_request(pos_req(REQ_READ, 8'hff, 8'hff));
        send_request(put_req(NEWLINE_CODE, 4'h0, 4'h0));
        send_request(pos_req(REQ_READ, 8'(COLS - 1), 8'(LINES - 2)));
        send_request(pos_req(REQ_READ, 8'(COLS - 1), 8'(LINES - 1)));
        send_request(pos_req(REQ_SETC, 8'd200, 8'd0));
        send_request(pos_req(REQ_SETC, 8'd0, 8'd0));
        send_request(clear_req(4'ha, 4'h5));
        send_request(pos_req(REQ_READ, 8'd0, 8'd0));
        send_request(pos_req(REQ_SETC, 8'd0, 8'(LINES - 1)));
        send_request(put_req(NEWLINE_CODE, 4'hf, 4'hf));
        send_request(put_req(8'h7e, 4'h6, 4'h9));
        send_request(clear_req(4'h0, 4'h0));
        send_request(pos_req(REQ_READ, 8'd3, 8'd2));

        // Random: mostly text runs and bottom-row scrolls, some noise, rare clears
        while (sent_count < ITEM_TARGET) begin
            calm_tail  = (sent_count >= ITEM_TARGET - TAIL_ITEMS);
            in_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 20;
            pick       = $urandom_range(0, 99);
            if (pick < 50)      text_run();
            else if (pick < 62) bottom_scroll();
            else if (pick < 98) noise_item();
            else                send_request(clear_req(4'($urandom), 4'($urandom)));
        end
        i_in_valid <= 1'b0;

        // Drain every outstanding result, then a short settle
        while (board.pending() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        board.finish_check();

        $display("Run covered %0d requests: %0d puts, %0d scrolls, %0d clears, %0d cell reads.",
                 board.accepted, board.puts, board.scrolls, board.clears, board.reads);
        $display("%0d results compared, %0d mismatches, %0d cycles.",
                 board.checked, board.failures, cycle_count);
        if (board.failures == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+sv
sv/tcw_pkg.sv
sv/text_console_writer.sv
sv/tcw_checker.sv
verif/tb.sv
